@@ rtl/core/nectx_pkg.sv @@
// nectx_pkg: shared types and timing constants for the nec ir frame transmitter
// no dependencies; imported by the sequencer and the top level

package nectx_pkg;

    // item kinds on the request channel
    localparam logic KIND_TICK  = 1'b0;
    localparam logic KIND_START = 1'b1;

    // waveform segments
    typedef enum logic [3:0] {
        SEG_IDLE       = 4'd0,
        SEG_HDR_MARK   = 4'd1,
        SEG_HDR_SPACE  = 4'd2,
        SEG_BIT_MARK   = 4'd3,
        SEG_BIT_SPACE  = 4'd4,
        SEG_STOP_MARK  = 4'd5,
        SEG_STOP_SPACE = 4'd6,
        SEG_REP_MARK   = 4'd7,
        SEG_REP_SPACE  = 4'd8,
        SEG_REP_BIT    = 4'd9,
        SEG_REP_GAP    = 4'd10
    } seg_t;

    localparam int TICK_W  = 17;
    localparam int PHASE_W = 5;
    localparam int BIT_W   = 6;
    localparam int REP_W   = 8;

    // segment lengths in microsecond ticks
    localparam logic [TICK_W-1:0] LEN_LEADER    = 17'd9000;
    localparam logic [TICK_W-1:0] LEN_HDR_SPACE = 17'd4500;
    localparam logic [TICK_W-1:0] LEN_SHORT     = 17'd560;
    localparam logic [TICK_W-1:0] LEN_ONE_SPACE = 17'd1690;
    localparam logic [TICK_W-1:0] LEN_STOP_GAP  = 17'd40000;
    localparam logic [TICK_W-1:0] LEN_REP_SPACE = 17'd2250;
    localparam logic [TICK_W-1:0] LEN_REP_GAP   = 17'd96000;

    // 38 khz carrier, one third duty
    localparam int CARRIER_KHZ    = 38;
    localparam int CARRIER_PERIOD = 1000 / CARRIER_KHZ;
    localparam int CARRIER_ON     = CARRIER_PERIOD / 3;
    localparam logic [PHASE_W-1:0] PHASE_PERIOD = PHASE_W'(CARRIER_PERIOD);
    localparam logic [PHASE_W-1:0] PHASE_ON     = PHASE_W'(CARRIER_ON);

    // number of data bits in a frame
    localparam logic [BIT_W-1:0] FRAME_BITS = 6'd32;

    typedef struct packed {
        logic led_on;
        logic busy_res;
        logic start_taken;
        logic sequence_done;
    } res_t;

    // lsb-first frame: addr lo, addr hi (or ~lo), cmd, ~cmd
    function automatic logic [31:0] build_frame(input logic [15:0] address,
                                                input logic [7:0]  command);
        logic [7:0] lo;
        logic [7:0] hi;
        lo = address[7:0];
        hi = (address[15:8] == 8'h00) ? ~lo : address[15:8];
        return {~command, command, hi, lo};
    endfunction

endpackage

@@ rtl/core/nectx_req_if.sv @@
// nectx_req_if: request channel of the nec ir transmitter (valid/ready + item)
// depends on nothing

interface nectx_req_if;
    logic        valid;
    logic        ready;
    logic        kind;
    logic [15:0] address;
    logic [7:0]  command;
    logic [7:0]  repeat_count;

    modport source (output valid, output kind, output address, output command,
                    output repeat_count, input ready);
    modport sink   (input valid, input kind, input address, input command,
                    input repeat_count, output ready);
endinterface

@@ rtl/core/nectx_rsp_if.sv @@
// nectx_rsp_if: result channel of the nec ir transmitter (valid/ready + word)
// depends on nothing

interface nectx_rsp_if;
    logic valid;
    logic ready;
    logic led_on;
    logic busy_res;
    logic start_taken;
    logic sequence_done;

    modport source (output valid, output led_on, output busy_res,
                    output start_taken, output sequence_done, input ready);
    modport sink   (input valid, input led_on, input busy_res,
                    input start_taken, input sequence_done, output ready);
endinterface

@@ rtl/core/nectx_seq.sv @@
// nectx_seq: segment sequencer and carrier generator, one step per accepted word
// depends on nectx_pkg

module nectx_seq
    import nectx_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        accept,
    input  logic        kind,
    input  logic [15:0] address,
    input  logic [7:0]  command,
    input  logic [7:0]  repeat_count,
    output res_t        res,
    output logic        busy
);

    seg_t               seg_reg, seg_next;
    logic [BIT_W-1:0]   bit_pos_reg, bit_pos_next;
    logic [31:0]        frame_reg, frame_next;
    logic [TICK_W-1:0]  ticks_reg, ticks_next;
    logic [PHASE_W-1:0] phase_reg, phase_next;
    logic [REP_W-1:0]   repeats_reg, repeats_next;

    logic [TICK_W-1:0]  ticks_inc;
    logic [PHASE_W-1:0] phase_inc;
    logic [BIT_W-1:0]   bit_inc;
    logic [TICK_W-1:0]  seg_len;
    logic               is_mark;
    logic               period_end;
    logic               seg_end;
    logic               last_gap;

    assign busy       = (seg_reg != SEG_IDLE);
    assign ticks_inc  = ticks_reg + TICK_W'(1);
    assign phase_inc  = phase_reg + PHASE_W'(1);
    assign bit_inc    = bit_pos_reg + BIT_W'(1);
    assign period_end = (phase_inc >= PHASE_PERIOD);
    assign is_mark    = seg_reg inside {SEG_HDR_MARK, SEG_BIT_MARK, SEG_STOP_MARK,
                                        SEG_REP_MARK, SEG_REP_BIT};
    assign last_gap   = seg_reg inside {SEG_STOP_SPACE, SEG_REP_GAP};
    // marks only end on a carrier period boundary
    assign seg_end    = (ticks_inc >= seg_len) && (!is_mark || period_end);

    always_comb
    begin
        case (seg_reg)
            SEG_HDR_MARK:   seg_len = LEN_LEADER;
            SEG_HDR_SPACE:  seg_len = LEN_HDR_SPACE;
            SEG_BIT_MARK:   seg_len = LEN_SHORT;
            SEG_BIT_SPACE:  seg_len = frame_reg[bit_pos_reg[4:0]] ? LEN_ONE_SPACE : LEN_SHORT;
            SEG_STOP_MARK:  seg_len = LEN_SHORT;
            SEG_STOP_SPACE: seg_len = LEN_STOP_GAP;
            SEG_REP_MARK:   seg_len = LEN_LEADER;
            SEG_REP_SPACE:  seg_len = LEN_REP_SPACE;
            SEG_REP_BIT:    seg_len = LEN_SHORT;
            SEG_REP_GAP:    seg_len = LEN_REP_GAP;
            default:        seg_len = '0;
        endcase
    end

    // next state
    always_comb
    begin
        seg_next     = seg_reg;
        bit_pos_next = bit_pos_reg;
        frame_next   = frame_reg;
        ticks_next   = ticks_reg;
        phase_next   = phase_reg;
        repeats_next = repeats_reg;
        if (accept)
        begin
            if (kind == KIND_START)
            begin
                if (!busy)
                begin
                    frame_next   = build_frame(address, command);
                    repeats_next = repeat_count;
                    bit_pos_next = '0;
                    seg_next     = SEG_HDR_MARK;
                    ticks_next   = '0;
                    phase_next   = '0;
                end
            end
            else if (busy)
            begin
                ticks_next = ticks_inc;
                if (is_mark)
                begin
                    phase_next = period_end ? '0 : phase_inc;
                end
                if (seg_end)
                begin
                    ticks_next = '0;
                    phase_next = '0;
                    case (seg_reg)
                        SEG_HDR_MARK:  seg_next = SEG_HDR_SPACE;
                        SEG_HDR_SPACE: seg_next = SEG_BIT_MARK;
                        SEG_BIT_MARK:  seg_next = SEG_BIT_SPACE;
                        SEG_BIT_SPACE:
                        begin
                            bit_pos_next = bit_inc;
                            seg_next = (bit_inc >= FRAME_BITS) ? SEG_STOP_MARK : SEG_BIT_MARK;
                        end
                        SEG_STOP_MARK: seg_next = SEG_STOP_SPACE;
                        SEG_REP_MARK:  seg_next = SEG_REP_SPACE;
                        SEG_REP_SPACE: seg_next = SEG_REP_BIT;
                        SEG_REP_BIT:   seg_next = SEG_REP_GAP;
                        SEG_STOP_SPACE, SEG_REP_GAP:
                        begin
                            if (repeats_reg != '0)
                            begin
                                repeats_next = repeats_reg - REP_W'(1);
                                seg_next     = SEG_REP_MARK;
                            end
                            else
                            begin
                                seg_next = SEG_IDLE;
                            end
                        end
                        default:       seg_next = SEG_IDLE;
                    endcase
                end
            end
        end
    end

    // result word
    always_comb
    begin
        res = '0;
        if (accept)
        begin
            if (kind == KIND_START)
            begin
                res.busy_res    = 1'b1;
                res.start_taken = !busy;
            end
            else if (busy)
            begin
                res.busy_res      = 1'b1;
                res.led_on        = is_mark && (phase_reg < PHASE_ON);
                res.sequence_done = seg_end && last_gap && (repeats_reg == '0);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seg_reg     <= SEG_IDLE;
            bit_pos_reg <= '0;
            frame_reg   <= '0;
            ticks_reg   <= '0;
            phase_reg   <= '0;
            repeats_reg <= '0;
        end
        else
        begin
            seg_reg     <= seg_next;
            bit_pos_reg <= bit_pos_next;
            frame_reg   <= frame_next;
            ticks_reg   <= ticks_next;
            phase_reg   <= phase_next;
            repeats_reg <= repeats_next;
        end
    end

endmodule

@@ rtl/core/nec_ir_frame_transmitter.sv @@
// nec_ir_frame_transmitter: nec ir frame and repeat-code generator, top level
// depends on nectx_pkg, nectx_req_if, nectx_rsp_if and nectx_seq
//
//   channel | dir | word
//   --------+-----+-----------------------------------------------
//   req     | in  | kind, address, command, repeat_count
//   rsp     | out | led_on, busy_res, start_taken, sequence_done
//
// one word in, one word out; a new word is taken every cycle while req.ready is high
// the result appears in the output register in the cycle after acceptance
// the output register is the only stage: req.ready drops only while that
// register holds an untaken word and rsp.ready is low
// reset (async, active low) returns the sequencer to idle and empties the output

module nec_ir_frame_transmitter
    import nectx_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    nectx_req_if.sink    req,
    nectx_rsp_if.source  rsp
);

    logic out_valid_reg;
    res_t res_reg;
    res_t res;
    logic accept;
    logic busy;

    assign req.ready = !out_valid_reg || rsp.ready;
    assign accept    = req.valid && req.ready;

    nectx_seq u_seq (
        .clk          (clk),
        .rst_n        (rst_n),
        .accept       (accept),
        .kind         (req.kind),
        .address      (req.address),
        .command      (req.command),
        .repeat_count (req.repeat_count),
        .res          (res),
        .busy         (busy)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            res_reg <= res;
        end
    end

    assign rsp.valid         = out_valid_reg;
    assign rsp.led_on        = res_reg.led_on;
    assign rsp.busy_res      = res_reg.busy_res;
    assign rsp.start_taken   = res_reg.start_taken;
    assign rsp.sequence_done = res_reg.sequence_done;

`ifndef SYNTH
    // a taken start always leaves the sequencer busy
    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        accept && (req.kind == KIND_START) && !busy |=> busy)
        else $error("sequencer not busy after a taken start");

    // a start word only shows as taken when the sequencer was idle
    a_taken_idle: assert property (@(posedge clk) disable iff (!rst_n)
        accept && (req.kind == KIND_START) |=> res_reg.start_taken == !$past(busy))
        else $error("start_taken disagrees with sequencer state");

    // end of sequence leaves the sequencer idle and gives a valid, busy, unlit result word
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        accept && res.sequence_done |=> !busy && rsp.valid && rsp.busy_res && !rsp.led_on)
        else $error("sequence_done without return to idle");
`endif

endmodule

@@ dv/nec_ir_frame_transmitter_test.sv @@
// nec_ir_frame_transmitter_test: self-checking bench for the nec ir frame transmitter
// drives start and tick words on req, predicts led level and status for every word on rsp
// depends on nectx_pkg, nectx_req_if, nectx_rsp_if and the rtl top level

module nec_ir_frame_transmitter_test;
    import nectx_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // waveform timing in microsecond ticks
    localparam logic [16:0] LEADER_US    = 17'd9000;
    localparam logic [16:0] HDR_SPACE_US = 17'd4500;
    localparam logic [16:0] SHORT_US     = 17'd560;
    localparam logic [16:0] ONE_SPACE_US = 17'd1690;
    localparam logic [16:0] STOP_GAP_US  = 17'd40000;
    localparam logic [16:0] REP_SPACE_US = 17'd2250;
    localparam logic [16:0] REP_GAP_US   = 17'd96000;
    localparam int unsigned CARRIER_US     = 1000 / 38;
    localparam int unsigned CARRIER_LIT_US = CARRIER_US / 3;

    localparam int unsigned MAX_REPORTS = 40;

    typedef enum logic [1:0] {
        PACE_SINK_SLOW,
        PACE_SOURCE_SLOW,
        PACE_FREE
    } pace_t;

    typedef struct packed {
        logic        kind;
        logic [15:0] address;
        logic [7:0]  command;
        logic [7:0]  repeat_count;
        pace_t       pace;
        logic        drain;
    } tx_word_t;

    typedef struct packed {
        seg_t        seg;
        logic [5:0]  bit_pos;
        logic [31:0] frame;
        logic [16:0] ticks;
        logic [4:0]  phase;
        logic [7:0]  reps;
        logic        sending;
    } nec_state_t;

    logic clk = 1'b0;
    logic rst_n;

    nectx_req_if req_ch();
    nectx_rsp_if rsp_ch();

    nec_ir_frame_transmitter dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    tx_word_t    queued_words[$];
    res_t        due_words[$];
    nec_state_t  model_state;
    nec_state_t  plan_state;
    int unsigned plan_words;
    int unsigned plan_done;
    logic        word_taken;
    pace_t       sink_pace;
    int unsigned src_calm;
    int unsigned snk_calm;
    int unsigned mismatches;
    int unsigned n_checked;
    int unsigned n_taken;
    int unsigned n_ignored;
    int unsigned n_done;
    int unsigned n_lit;

    // one word of the transmitter: a start loads the frame, a tick advances the waveform
    task automatic advance_nec_waveform(inout nec_state_t s, input logic kind,
                                        input logic [15:0] address, input logic [7:0] command,
                                        input logic [7:0] repeat_count, output res_t r);
        logic [16:0] seg_len;
        logic        is_mark;
        logic        seg_over;
        logic [7:0]  lo;
        logic [7:0]  hi;
        r = '0;
        if (kind == KIND_START)
        begin
            if (!s.sending)
            begin
                lo = address[7:0];
                hi = address[15:8];
                if (hi == 8'h00)
                    hi = ~lo;
                s.frame   = {~command, command, hi, lo};
                s.reps    = repeat_count;
                s.bit_pos = '0;
                s.sending = 1'b1;
                s.seg     = SEG_HDR_MARK;
                s.ticks   = '0;
                s.phase   = '0;
                r.start_taken = 1'b1;
            end
            r.busy_res = s.sending;
        end
        else if (s.sending)
        begin
            is_mark = 1'b0;
            case (s.seg)
                SEG_HDR_MARK:   begin seg_len = LEADER_US;    is_mark = 1'b1; end
                SEG_HDR_SPACE:  seg_len = HDR_SPACE_US;
                SEG_BIT_MARK:   begin seg_len = SHORT_US;     is_mark = 1'b1; end
                SEG_BIT_SPACE:  seg_len = s.frame[s.bit_pos[4:0]] ? ONE_SPACE_US : SHORT_US;
                SEG_STOP_MARK:  begin seg_len = SHORT_US;     is_mark = 1'b1; end
                SEG_STOP_SPACE: seg_len = STOP_GAP_US;
                SEG_REP_MARK:   begin seg_len = LEADER_US;    is_mark = 1'b1; end
                SEG_REP_SPACE:  seg_len = REP_SPACE_US;
                SEG_REP_BIT:    begin seg_len = SHORT_US;     is_mark = 1'b1; end
                SEG_REP_GAP:    seg_len = REP_GAP_US;
                default:        seg_len = '0;
            endcase
            r.busy_res = 1'b1;
            s.ticks = s.ticks + 17'd1;
            seg_over = 1'b0;
            if (is_mark)
            begin
                r.led_on = (s.phase < CARRIER_LIT_US);
                s.phase = s.phase + 5'd1;
                // a mark only ends on a carrier period boundary
                if (s.phase >= CARRIER_US)
                begin
                    s.phase = '0;
                    seg_over = (s.ticks >= seg_len);
                end
            end
            else
                seg_over = (s.ticks >= seg_len);
            if (seg_over)
            begin
                s.ticks = '0;
                s.phase = '0;
                case (s.seg)
                    SEG_HDR_MARK:  s.seg = SEG_HDR_SPACE;
                    SEG_HDR_SPACE: s.seg = SEG_BIT_MARK;
                    SEG_BIT_MARK:  s.seg = SEG_BIT_SPACE;
                    SEG_BIT_SPACE:
                    begin
                        s.bit_pos = s.bit_pos + 6'd1;
                        if (s.bit_pos >= 6'd32)
                            s.seg = SEG_STOP_MARK;
                        else
                            s.seg = SEG_BIT_MARK;
                    end
                    SEG_STOP_MARK: s.seg = SEG_STOP_SPACE;
                    SEG_REP_MARK:  s.seg = SEG_REP_SPACE;
                    SEG_REP_SPACE: s.seg = SEG_REP_BIT;
                    SEG_REP_BIT:   s.seg = SEG_REP_GAP;
                    SEG_STOP_SPACE, SEG_REP_GAP:
                    begin
                        if (s.reps != 8'd0)
                        begin
                            s.reps = s.reps - 8'd1;
                            s.seg  = SEG_REP_MARK;
                        end
                        else
                        begin
                            s.seg     = SEG_IDLE;
                            s.sending = 1'b0;
                            r.sequence_done = 1'b1;
                        end
                    end
                    default:
                    begin
                        s.seg     = SEG_IDLE;
                        s.sending = 1'b0;
                    end
                endcase
            end
        end
    endtask

    function automatic int unsigned idle_pct(input pace_t pace, input logic source);
        case (pace)
            PACE_SINK_SLOW:   return source ? 20 : 82;
            PACE_SOURCE_SLOW: return source ? 82 : 20;
            default:          return 0;
        endcase
    endfunction

    // the plan copy of the state tells the generator whether a start will be taken
    task automatic queue_word(input logic kind, input logic [15:0] address,
                              input logic [7:0] command, input logic [7:0] repeat_count,
                              input pace_t pace, input logic drain);
        tx_word_t w;
        res_t     r;
        w.kind         = kind;
        w.address      = address;
        w.command      = command;
        w.repeat_count = repeat_count;
        w.pace         = pace;
        w.drain        = drain;
        advance_nec_waveform(plan_state, kind, address, command, repeat_count, r);
        if (r.sequence_done)
            plan_done++;
        plan_words++;
        queued_words.push_back(w);
    endtask

    task automatic queue_random(input pace_t pace, input int unsigned n_words,
                                input int unsigned done_goal);
        int unsigned first;
        int unsigned gap;
        first = plan_words;
        while (plan_words - first < n_words || plan_done < done_goal)
        begin
            if (plan_state.sending)
            begin
                // busy: ticks with junk fields, now and then a start that must be ignored
                if ($urandom_range(0, 63) == 0)
                    queue_word(KIND_START, 16'($urandom), 8'($urandom), 8'($urandom),
                               pace, 1'b0);
                else
                    queue_word(KIND_TICK, 16'($urandom), 8'($urandom), 8'($urandom),
                               pace, $urandom_range(0, 4999) == 0);
            end
            else
            begin
                // back-to-back start right after the first sequence ends
                gap = (plan_done == 1) ? 0 : $urandom_range(1, 6);
                repeat (gap)
                    queue_word(KIND_TICK, 16'($urandom), 8'($urandom), 8'($urandom),
                               pace, 1'b0);
                queue_word(KIND_START, 16'($urandom), 8'($urandom), 8'd0, pace, 1'b0);
            end
        end
    endtask

    task automatic flag_mismatch(input string what, input logic want, input logic got);
        if (want !== got)
        begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
                $display("[%0t] %s mismatch: expected %0b, got %0b", $time, what, want, got);
        end
    endtask

    // source side: present queued words, hold off where a drain is asked
    always @(negedge clk)
    begin : source_side
        tx_word_t w;
        if (!rst_n)
            req_ch.valid <= 1'b0;
        else
        begin
            if (src_calm != 0)
                src_calm--;
            else if ($urandom_range(0, 399) == 0)
                src_calm = $urandom_range(20, 200);
            if (!req_ch.valid || word_taken)
            begin
                if (queued_words.size() != 0
                    && !(queued_words[0].drain && due_words.size() != 0)
                    && (src_calm != 0
                        || $urandom_range(0, 99) >= idle_pct(queued_words[0].pace, 1'b1)))
                begin
                    w = queued_words.pop_front();
                    req_ch.valid        <= 1'b1;
                    req_ch.kind         <= w.kind;
                    req_ch.address      <= w.address;
                    req_ch.command      <= w.command;
                    req_ch.repeat_count <= w.repeat_count;
                    sink_pace           <= w.pace;
                end
                else
                    req_ch.valid <= 1'b0;
            end
        end
    end

    always @(negedge clk)
    begin : sink_side
        if (snk_calm != 0)
            snk_calm--;
        else if ($urandom_range(0, 399) == 0)
            snk_calm = $urandom_range(20, 200);
        rsp_ch.ready <= (snk_calm != 0) || ($urandom_range(0, 99) >= idle_pct(sink_pace, 1'b0));
    end

    always @(posedge clk)
    begin : check_side
        res_t want;
        res_t got;
        word_taken = 1'b0;
        if (rst_n)
        begin
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                got.led_on        = rsp_ch.led_on;
                got.busy_res      = rsp_ch.busy_res;
                got.start_taken   = rsp_ch.start_taken;
                got.sequence_done = rsp_ch.sequence_done;
                if (due_words.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("[%0t] result word with nothing expected: expected none, got %b",
                                 $time, got);
                end
                else
                begin
                    want = due_words.pop_front();
                    flag_mismatch("led_on", want.led_on, got.led_on);
                    flag_mismatch("busy_res", want.busy_res, got.busy_res);
                    flag_mismatch("start_taken", want.start_taken, got.start_taken);
                    flag_mismatch("sequence_done", want.sequence_done, got.sequence_done);
                    n_checked++;
                end
            end
            if (req_ch.valid && req_ch.ready)
            begin
                word_taken = 1'b1;
                advance_nec_waveform(model_state, req_ch.kind, req_ch.address, req_ch.command,
                                     req_ch.repeat_count, want);
                due_words.push_back(want);
                if (want.start_taken)
                    n_taken++;
                else if (req_ch.kind == KIND_START)
                    n_ignored++;
                if (want.sequence_done)
                    n_done++;
                if (want.led_on)
                    n_lit++;
            end
        end
    end

    initial
    begin
        #(40_000_000);
        $display("[FAIL] regression broken");
        $finish;
    end

    initial
    begin
        rst_n               = 1'b0;
        req_ch.valid        = 1'b0;
        req_ch.kind         = KIND_TICK;
        req_ch.address      = '0;
        req_ch.command      = '0;
        req_ch.repeat_count = '0;
        rsp_ch.ready        = 1'b0;
        word_taken  = 1'b0;
        sink_pace   = PACE_SINK_SLOW;
        src_calm    = 0;
        snk_calm    = 0;
        mismatches  = 0;
        n_checked   = 0;
        n_taken     = 0;
        n_ignored   = 0;
        n_done      = 0;
        n_lit       = 0;
        plan_words  = 0;
        plan_done   = 0;
        model_state = '0;
        model_state.seg = SEG_IDLE;
        plan_state  = model_state;

        // directed: idle ticks, inverted-address frame with one repeat, starts while busy
        queue_word(KIND_TICK, 16'hFFFF, 8'hFF, 8'hFF, PACE_SINK_SLOW, 1'b0);
        queue_word(KIND_TICK, 16'h0000, 8'h00, 8'h00, PACE_SINK_SLOW, 1'b0);
        queue_word(KIND_START, 16'h0000, 8'hFF, 8'd1, PACE_SINK_SLOW, 1'b0);
        queue_word(KIND_START, 16'hFFFF, 8'h00, 8'hFF, PACE_SINK_SLOW, 1'b0);
        queue_word(KIND_TICK, 16'hFFFF, 8'hFF, 8'hFF, PACE_SINK_SLOW, 1'b0);
        queue_word(KIND_START, 16'h8001, 8'h7E, 8'h80, PACE_SINK_SLOW, 1'b0);
        queue_word(KIND_TICK, 16'h0000, 8'h00, 8'h00, PACE_SINK_SLOW, 1'b0);

        queue_random(PACE_SINK_SLOW, 900, 0);
        queue_word(KIND_TICK, 16'h5A5A, 8'hA5, 8'h3C, PACE_SOURCE_SLOW, 1'b1);
        queue_random(PACE_SOURCE_SLOW, 700, 0);
        // full rate for the last stretch
        queue_word(KIND_TICK, 16'hA5A5, 8'h5A, 8'hC3, PACE_FREE, 1'b1);
        queue_random(PACE_FREE, 400, 0);

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        while (queued_words.size() != 0 || req_ch.valid)
            @(posedge clk);
        while (due_words.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);

        $display("checked %0d result words, %0d with the led lit", n_checked, n_lit);
        $display("%0d starts taken, %0d ignored while busy, %0d sequences completed",
                 n_taken, n_ignored, n_done);
        if (mismatches == 0 && due_words.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

@@ files.f @@
rtl/core/nectx_pkg.sv
rtl/core/nectx_req_if.sv
rtl/core/nectx_rsp_if.sv
rtl/core/nectx_seq.sv
rtl/core/nec_ir_frame_transmitter.sv
dv/nec_ir_frame_transmitter_test.sv
